// ===== src/rvm_pkg.sv =====
`timescale 1ns / 1ps

package rvm_pkg;

    localparam int WORD_W = 32;
    localparam int OPC_W  = 8;

    localparam logic [OPC_W-1:0] OP_HALT = 8'd0;
    localparam logic [OPC_W-1:0] OP_MOVE = 8'd1;
    localparam logic [OPC_W-1:0] OP_LOAD = 8'd2;
    localparam logic [OPC_W-1:0] OP_ADD  = 8'd3;
    localparam logic [OPC_W-1:0] OP_SUB  = 8'd4;
    localparam logic [OPC_W-1:0] OP_MUL  = 8'd5;
    localparam logic [OPC_W-1:0] OP_DIV  = 8'd6;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic div_take;
        logic commit;
    } rvm_cmd_t;

    typedef struct packed {
        logic op_div;
        logic div_done;
        logic out_free;
    } rvm_sts_t;

endpackage

// ===== src/rvm_divider.sv =====
`timescale 1ns / 1ps

module rvm_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rvm_pkg::WORD_W-1:0]  dividend,
    input  logic [rvm_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [rvm_pkg::WORD_W-1:0]  quotient
);

    localparam int W  = rvm_pkg::WORD_W;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic [W+1:0]  diff;

    // restoring step: one quotient bit per cycle
    assign diff = {1'b0, rem_reg, quo_reg[W-1]} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[W+1]) begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/rvm_ctrl.sv =====
`timescale 1ns / 1ps

module rvm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rvm_pkg::rvm_sts_t  sts,
    output rvm_pkg::rvm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = sts.op_div ? ST_DIVIDE : ST_COMMIT;
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.load     = (state_reg == ST_IDLE) && s_valid;
    assign cmd.read     = (state_reg == ST_READ);
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.div_take = (state_reg == ST_DIVIDE) && sts.div_done;
    assign cmd.commit   = (state_reg == ST_COMMIT) && sts.out_free;

endmodule

// ===== src/rvm_datapath.sv =====
`timescale 1ns / 1ps

module rvm_datapath #(
    parameter int REG_COUNT = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [rvm_pkg::WORD_W-1:0]  s_instruction,
    input  rvm_pkg::rvm_cmd_t           cmd,
    output rvm_pkg::rvm_sts_t           sts,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic                        m_halted,
    output logic                        m_ignored,
    output logic                        m_wrote,
    output logic [1:0]                  m_dest_index,
    output logic [rvm_pkg::WORD_W-1:0]  m_dest_value,
    output logic                        m_divide_by_zero,
    output logic                        m_unknown_opcode
);

    localparam int W  = rvm_pkg::WORD_W;
    localparam int IW = $clog2(REG_COUNT);

    // register field modulo the file size, by repeated subtraction
    function automatic logic [IW-1:0] reg_sel(input logic [3:0] field);
        logic [4:0] v;
        v = {1'b0, field};
        for (int i = 0; i < 8; i++) begin
            if (v >= 5'(REG_COUNT)) begin
                v = v - 5'(REG_COUNT);
            end
        end
        return IW'(v);
    endfunction

    logic [W-1:0]          instr_reg;
    logic [W-1:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0]  valid_reg;
    logic [W-1:0]          rdb_reg;
    logic [W-1:0]          rdc_reg;
    logic                  rdb_vld_reg;
    logic                  rdc_vld_reg;
    logic                  halt_flag_reg;

    logic                  res_halted_reg;
    logic                  res_ignored_reg;
    logic                  res_wrote_reg;
    logic [IW-1:0]         res_dest_reg;
    logic [W-1:0]          res_value_reg;
    logic                  res_dz_reg;
    logic                  res_unk_reg;

    logic                  res_halted_next;
    logic                  res_ignored_next;
    logic                  res_wrote_next;
    logic [IW-1:0]         res_dest_next;
    logic [W-1:0]          res_value_next;
    logic                  res_dz_next;
    logic                  res_unk_next;

    logic                  m_valid_reg;
    logic                  m_halted_reg;
    logic                  m_ignored_reg;
    logic                  m_wrote_reg;
    logic [1:0]            m_dest_index_reg;
    logic [W-1:0]          m_dest_value_reg;
    logic                  m_dz_reg;
    logic                  m_unk_reg;

    logic [rvm_pkg::OPC_W-1:0] opcode;
    logic [IW-1:0]         ra;
    logic [IW-1:0]         rb;
    logic [IW-1:0]         rc;
    logic [W-1:0]          opb;
    logic [W-1:0]          opc;
    logic [3:0]            dest_ext;
    logic                  div_start;
    logic                  div_done;
    logic [W-1:0]          div_quo;

    assign opcode = instr_reg[31:24];
    assign ra     = reg_sel(instr_reg[23:20]);
    assign rb     = reg_sel(instr_reg[19:16]);
    assign rc     = reg_sel(instr_reg[15:12]);
    assign opb    = rdb_vld_reg ? rdb_reg : '0;
    assign opc    = rdc_vld_reg ? rdc_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            instr_reg <= s_instruction;
        end
        if (cmd.read) begin
            rdb_reg     <= mem[rb];
            rdc_reg     <= mem[rc];
            rdb_vld_reg <= valid_reg[rb];
            rdc_vld_reg <= valid_reg[rc];
        end
        if (cmd.commit && res_wrote_reg) begin
            mem[res_dest_reg] <= res_value_reg;
        end
    end

    always_comb begin
        res_halted_next  = halt_flag_reg;
        res_ignored_next = 1'b0;
        res_wrote_next   = 1'b0;
        res_dest_next    = '0;
        res_value_next   = '0;
        res_dz_next      = 1'b0;
        res_unk_next     = 1'b0;
        if (halt_flag_reg) begin
            res_ignored_next = 1'b1;
        end else begin
            case (opcode)
                rvm_pkg::OP_HALT: begin
                    res_halted_next = 1'b1;
                end
                rvm_pkg::OP_MOVE: begin
                    res_wrote_next = 1'b1;
                    res_dest_next  = rb;
                    res_value_next = opc;
                end
                rvm_pkg::OP_LOAD: begin
                    res_wrote_next = 1'b1;
                    res_dest_next  = ra;
                    res_value_next = {24'd0, instr_reg[7:0]};
                end
                rvm_pkg::OP_ADD: begin
                    res_wrote_next = 1'b1;
                    res_dest_next  = ra;
                    res_value_next = opb + opc;
                end
                rvm_pkg::OP_SUB: begin
                    res_wrote_next = 1'b1;
                    res_dest_next  = ra;
                    res_value_next = opb - opc;
                end
                rvm_pkg::OP_MUL: begin
                    res_wrote_next = 1'b1;
                    res_dest_next  = ra;
                    res_value_next = W'(opb * opc);
                end
                rvm_pkg::OP_DIV: begin
                    // quotient arrives later; zero divisor yields all ones there
                    res_wrote_next = 1'b1;
                    res_dest_next  = ra;
                    res_dz_next    = (opc == '0);
                end
                default: begin
                    res_unk_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_halted_reg  <= res_halted_next;
            res_ignored_reg <= res_ignored_next;
            res_wrote_reg   <= res_wrote_next;
            res_dest_reg    <= res_dest_next;
            res_value_reg   <= res_value_next;
            res_dz_reg      <= res_dz_next;
            res_unk_reg     <= res_unk_next;
        end else if (cmd.div_take) begin
            res_value_reg <= div_quo;
        end
    end

    assign div_start = cmd.exec && sts.op_div;

    rvm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (opb),
        .divisor  (opc),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign dest_ext = 4'(res_dest_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            halt_flag_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_valid_reg   <= 1'b1;
                halt_flag_reg <= halt_flag_reg | res_halted_reg;
                if (res_wrote_reg) begin
                    valid_reg[res_dest_reg] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_halted_reg     <= res_halted_reg;
            m_ignored_reg    <= res_ignored_reg;
            m_wrote_reg      <= res_wrote_reg;
            m_dest_index_reg <= res_wrote_reg ? dest_ext[1:0] : 2'd0;
            m_dest_value_reg <= res_wrote_reg ? res_value_reg : '0;
            m_dz_reg         <= res_dz_reg;
            m_unk_reg        <= res_unk_reg;
        end
    end

    assign sts.op_div   = (opcode == rvm_pkg::OP_DIV) && !halt_flag_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_halted         = m_halted_reg;
    assign m_ignored        = m_ignored_reg;
    assign m_wrote          = m_wrote_reg;
    assign m_dest_index     = m_dest_index_reg;
    assign m_dest_value     = m_dest_value_reg;
    assign m_divide_by_zero = m_dz_reg;
    assign m_unknown_opcode = m_unk_reg;

endmodule

// ===== src/register_vm_instruction_execute.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Moves
// --------  --------------------------------------  -------------------------------
// s_        s_valid, s_ready, s_instruction         one instruction word per request
// m_        m_valid, m_ready, m_halted .. m_unknown one execution result per request
//
// Non-divide instructions pass through accept, register read, execute and
// commit before the next accept slot; divide adds a wait for the bit-serial
// divider between execute and commit. Synchronous active-low reset clears the
// register file valid bits and the halt flag; the file reads as zero until
// written. A stalled m_ holds its result; a new request is taken meanwhile and
// waits at commit until the output register frees.

module register_vm_instruction_execute #(
    parameter int REG_COUNT = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rvm_pkg::WORD_W-1:0]  s_instruction,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_halted,
    output logic                        m_ignored,
    output logic                        m_wrote,
    output logic [1:0]                  m_dest_index,
    output logic [rvm_pkg::WORD_W-1:0]  m_dest_value,
    output logic                        m_divide_by_zero,
    output logic                        m_unknown_opcode
);

    rvm_pkg::rvm_cmd_t cmd;
    rvm_pkg::rvm_sts_t sts;

    rvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rvm_datapath #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_instruction    (s_instruction),
        .cmd              (cmd),
        .sts              (sts),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_halted         (m_halted),
        .m_ignored        (m_ignored),
        .m_wrote          (m_wrote),
        .m_dest_index     (m_dest_index),
        .m_dest_value     (m_dest_value),
        .m_divide_by_zero (m_divide_by_zero),
        .m_unknown_opcode (m_unknown_opcode)
    );

endmodule
